// ===== sv/lazy_range_add_sum_tree_unit_assert.svh =====
// Assertion macros shared by the checker of the range add / range sum tree unit.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef LAZY_RANGE_ADD_SUM_TREE_UNIT_ASSERT_SVH
`define LAZY_RANGE_ADD_SUM_TREE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRAST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRAST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/lrast_pkg.sv =====
// Package of the range add / range sum tree unit.
// Holds default sizes, field widths and the operation codes; depends on nothing.
package lrast_pkg;

    localparam int LEAVES_DEF     = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 10;
    localparam int LEFT_W   = 10;
    localparam int RIGHT_W  = 11;
    localparam int AMOUNT_W = 32;
    localparam int SUM_W    = 32;
    localparam int SIZE_W   = 11;

    localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;

    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REBUILD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SUM     = 2'd3;

endpackage

// ===== sv/lrast_ram.sv =====
// Generic single-write, dual-read memory with registered read data.
// Stand-alone; used for the node sums and the pending increments.
module lrast_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic [$clog2(DEPTH)-1:0] i_ra0,
    input  logic [$clog2(DEPTH)-1:0] i_ra1,
    output logic [WIDTH-1:0]         o_rd0,
    output logic [WIDTH-1:0]         o_rd1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd0 <= r_mem[i_ra0];
        o_rd1 <= r_mem[i_ra1];
    end
endmodule

// ===== sv/lrast_alu.sv =====
// Shared node arithmetic unit: y = a + b + (c << k), wrapping at the data width.
// Stand-alone; the top level's sequencer feeds it for the node sum updates.
module lrast_alu #(
    parameter int DW = 32,
    parameter int KW = 4
) (
    input  logic [DW-1:0] i_a,
    input  logic [DW-1:0] i_b,
    input  logic [DW-1:0] i_c,
    input  logic [KW-1:0] i_k,
    output logic [DW-1:0] o_y
);
    assign o_y = i_a + i_b + (i_c << i_k);
endmodule

// ===== sv/lazy_range_add_sum_tree_unit.sv =====
// Range add / range sum tree unit: sequencer, two node memories and the shared ALU.
// Depends on lrast_pkg, lrast_ram and lrast_alu.
//
// Usage:
// - Request channel: i_valid / o_stall with i_func, i_position, i_left, i_right,
//   i_amount. A request is taken at an edge with i_valid high and o_stall low.
// - Result channel: o_valid / i_stall with o_sum, o_status. A range add or range
//   sum gives one result; a leaf write or a rebuild gives none.
// - Configuration: i_cfg_valid / o_cfg_ready with i_cfg_data (leaves in use).
//   Write it only while no request is in flight.
// - One request is worked on at a time; o_stall is high until it is done and,
//   for a result, until the result has been taken.
// - A range add or sum first pushes down the pending increments along two boundary
//   paths, then visits the covering nodes, then for an add refreshes the two
//   paths. Every step reads the memories through a registered read.
// - After reset a clearing pass zeroes both memories; o_stall is high meanwhile.
//   Configuration writes are taken at all times.
// - While i_stall holds a result, o_sum and o_status stay unchanged.
module lazy_range_add_sum_tree_unit #(
    parameter int LEAVES     = lrast_pkg::LEAVES_DEF,
    parameter int DATA_WIDTH = lrast_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lrast_pkg::FUNC_W-1:0]        i_func,
    input  logic [lrast_pkg::POS_W-1:0]         i_position,
    input  logic [lrast_pkg::LEFT_W-1:0]        i_left,
    input  logic [lrast_pkg::RIGHT_W-1:0]       i_right,
    input  logic signed [lrast_pkg::AMOUNT_W-1:0] i_amount,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [lrast_pkg::SUM_W-1:0]  o_sum,
    output logic                                o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lrast_pkg::SIZE_W-1:0]        i_cfg_data
);
    import lrast_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int DEPTH = 2 * LEAVES;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = AW + 1;
    localparam int CW    = $clog2(LEAVES + 1);
    localparam int KW    = $clog2(NW + 1);
    localparam int CMPW  = (NW > SIZE_W) ? NW : SIZE_W;
    localparam logic [AW-1:0]   LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CMPW-1:0] LEAVES_C  = CMPW'(LEAVES);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WLEAF, S_RB_CHK, S_RB_RD, S_RB_WR, S_CHECK,
        S_PD_CHK, S_PD_RD1, S_PD_RD2, S_PD_W1, S_PD_W2, S_PD_W3,
        S_LP_CHK, S_LP_R, S_LP_NEXT, S_AN_RD, S_AN_WR,
        S_RF_CHK, S_RF_RD, S_RF_WR, S_OUT
    } t_state;

    t_state              r_state;
    logic [SIZE_W-1:0]   r_size;
    logic [AW-1:0]       r_clr_addr;
    logic [FUNC_W-1:0]   r_func;
    logic [POS_W-1:0]    r_pos;
    logic [LEFT_W-1:0]   r_left;
    logic [RIGHT_W-1:0]  r_right;
    logic [DW-1:0]       r_amount;
    logic [CW-1:0]       r_n;
    logic [KW-1:0]       r_h;
    logic [NW-1:0]       r_l;
    logic [NW-1:0]       r_r;
    logic [NW-1:0]       r_p;
    logic [NW-1:0]       r_pl;
    logic [NW-1:0]       r_pr;
    logic [KW-1:0]       r_s;
    logic [KW-1:0]       r_k;
    logic                r_path;
    logic                r_ret;
    logic [AW-1:0]       r_cur;
    logic [AW-1:0]       r_rb;
    logic [DW-1:0]       r_d;
    logic [DW-1:0]       r_s0;
    logic [DW-1:0]       r_s1;
    logic [DW-1:0]       r_pe1;
    logic [SUM_W-1:0]    r_acc;
    logic [SUM_W-1:0]    r_out_sum;
    logic                r_out_status;

    logic [CMPW-1:0] size_x;
    logic [CW-1:0]   n_eff;
    logic [KW-1:0]   h_eff;
    logic [NW-1:0]   n_w;
    logic [CMPW-1:0] n_x;
    logic            bad_range;
    logic [AW-1:0]   pd_i;
    logic [AW-1:0]   pd_c0;
    logic [AW-1:0]   pd_c1;
    logic [AW-1:0]   rf_c0;
    logic [AW-1:0]   rf_c1;
    logic [AW-1:0]   rb_c0;
    logic [AW-1:0]   rb_c1;
    logic [KW-1:0]   pd_k;

    logic            sum_we,  pend_we;
    logic [AW-1:0]   sum_wa,  pend_wa;
    logic [DW-1:0]   sum_wd,  pend_wd;
    logic [AW-1:0]   sum_ra0, sum_ra1, pend_ra0, pend_ra1;
    logic [DW-1:0]   sum_rd0, sum_rd1, pend_rd0, pend_rd1;

    logic [DW-1:0]   alu_a, alu_b, alu_c, alu_y;
    logic [KW-1:0]   alu_k;

    // Leaf count seen by the tree: zero acts as one, and it saturates at LEAVES.
    always_comb begin
        size_x = CMPW'(r_size);
        if (size_x == '0) begin
            n_eff = CW'(1);
        end else if (size_x > LEAVES_C) begin
            n_eff = CW'(LEAVES);
        end else begin
            n_eff = CW'(size_x);
        end
    end

    always_comb begin
        h_eff = '0;
        for (int b = 0; b < CW; b++) begin
            if (n_eff[b]) begin
                h_eff = KW'(b + 1);
            end
        end
    end

    assign n_w       = NW'(r_n);
    assign n_x       = CMPW'(r_n);
    assign bad_range = (CMPW'(r_left) >= CMPW'(r_right)) || (CMPW'(r_right) > n_x);
    assign pd_i      = AW'(r_p >> r_s);
    assign pd_c0     = {pd_i[AW-2:0], 1'b0};
    assign pd_c1     = {pd_i[AW-2:0], 1'b1};
    assign pd_k      = r_s - KW'(1);
    assign rf_c0     = {r_p[AW-2:0], 1'b0};
    assign rf_c1     = {r_p[AW-2:0], 1'b1};
    assign rb_c0     = {r_rb[AW-2:0], 1'b0};
    assign rb_c1     = {r_rb[AW-2:0], 1'b1};

    lrast_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_sum_ram (
        .i_clk(i_clk), .i_we(sum_we), .i_wa(sum_wa), .i_wd(sum_wd),
        .i_ra0(sum_ra0), .i_ra1(sum_ra1), .o_rd0(sum_rd0), .o_rd1(sum_rd1)
    );

    lrast_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_pend_ram (
        .i_clk(i_clk), .i_we(pend_we), .i_wa(pend_wa), .i_wd(pend_wd),
        .i_ra0(pend_ra0), .i_ra1(pend_ra1), .o_rd0(pend_rd0), .o_rd1(pend_rd1)
    );

    lrast_alu #(.DW(DW), .KW(KW)) u_alu (
        .i_a(alu_a), .i_b(alu_b), .i_c(alu_c), .i_k(alu_k), .o_y(alu_y)
    );

    // Memory addressing, write enables and ALU operands per sequencer step.
    always_comb begin
        sum_we   = 1'b0;
        sum_wa   = r_cur;
        sum_wd   = alu_y;
        pend_we  = 1'b0;
        pend_wa  = r_cur;
        pend_wd  = pend_rd0 + r_amount;
        sum_ra0  = r_cur;
        sum_ra1  = r_cur;
        pend_ra0 = r_cur;
        pend_ra1 = r_cur;
        alu_a    = sum_rd0;
        alu_b    = '0;
        alu_c    = '0;
        alu_k    = '0;
        case (r_state)
            S_CLEAR: begin
                sum_we  = 1'b1;
                sum_wa  = r_clr_addr;
                sum_wd  = '0;
                pend_we = 1'b1;
                pend_wa = r_clr_addr;
                pend_wd = '0;
            end
            S_WLEAF: begin
                sum_we = CMPW'(r_pos) < n_x;
                sum_wa = AW'(CMPW'(r_pos) + n_x);
                sum_wd = r_amount;
            end
            S_RB_RD: begin
                sum_ra0 = rb_c0;
                sum_ra1 = rb_c1;
            end
            S_RB_WR: begin
                alu_b  = sum_rd1;
                sum_we = 1'b1;
                sum_wa = r_rb;
            end
            S_PD_RD1: begin
                pend_ra0 = pd_i;
                sum_ra0  = pd_c0;
                sum_ra1  = pd_c1;
            end
            S_PD_RD2: begin
                pend_ra0 = pd_c0;
                pend_ra1 = pd_c1;
            end
            S_PD_W1: begin
                alu_a   = r_s0;
                alu_c   = r_d;
                alu_k   = pd_k;
                sum_we  = 1'b1;
                sum_wa  = pd_c0;
                pend_we = NW'(pd_c0) < n_w;
                pend_wa = pd_c0;
                pend_wd = pend_rd0 + r_d;
            end
            S_PD_W2: begin
                alu_a   = r_s1;
                alu_c   = r_d;
                alu_k   = pd_k;
                sum_we  = 1'b1;
                sum_wa  = pd_c1;
                pend_we = NW'(pd_c1) < n_w;
                pend_wa = pd_c1;
                pend_wd = r_pe1 + r_d;
            end
            S_PD_W3: begin
                pend_we = 1'b1;
                pend_wa = pd_i;
                pend_wd = '0;
            end
            S_AN_WR: begin
                alu_c   = r_amount;
                alu_k   = r_k;
                sum_we  = r_func == FUNC_ADD;
                pend_we = (r_func == FUNC_ADD) && (NW'(r_cur) < n_w);
            end
            S_RF_RD: begin
                sum_ra0  = rf_c0;
                sum_ra1  = rf_c1;
                pend_ra0 = AW'(r_p);
            end
            S_RF_WR: begin
                alu_b  = sum_rd1;
                alu_c  = pend_rd0;
                alu_k  = r_k;
                sum_we = 1'b1;
                sum_wa = AW'(r_p);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_size       <= SIZE_RST;
            r_clr_addr   <= '0;
            r_out_status <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_func   <= i_func;
                        r_pos    <= i_position;
                        r_left   <= i_left;
                        r_right  <= i_right;
                        r_amount <= DW'(i_amount);
                        r_n      <= n_eff;
                        r_h      <= h_eff;
                        r_rb     <= AW'(n_eff - CW'(1));
                        case (i_func)
                            FUNC_WRITE:   r_state <= S_WLEAF;
                            FUNC_REBUILD: r_state <= S_RB_CHK;
                            default:      r_state <= S_CHECK;
                        endcase
                    end
                end
                S_WLEAF: r_state <= S_IDLE;
                S_RB_CHK: r_state <= (r_rb == '0) ? S_IDLE : S_RB_RD;
                S_RB_RD: r_state <= S_RB_WR;
                S_RB_WR: begin
                    r_rb    <= r_rb - AW'(1);
                    r_state <= S_RB_CHK;
                end
                S_CHECK: begin
                    r_acc <= '0;
                    if (bad_range) begin
                        r_out_sum    <= '0;
                        r_out_status <= 1'b1;
                        r_state      <= S_OUT;
                    end else begin
                        r_l     <= NW'(r_left) + n_w;
                        r_r     <= NW'(r_right) + n_w;
                        r_p     <= NW'(r_left) + n_w;
                        r_pl    <= NW'(r_left) + n_w;
                        r_pr    <= NW'(r_right) + n_w - NW'(1);
                        r_s     <= r_h;
                        r_path  <= 1'b0;
                        r_state <= S_PD_CHK;
                    end
                end
                S_PD_CHK: begin
                    if (r_s == '0) begin
                        if (!r_path) begin
                            r_path <= 1'b1;
                            r_p    <= r_pr;
                            r_s    <= r_h;
                        end else begin
                            r_k     <= '0;
                            r_state <= S_LP_CHK;
                        end
                    end else begin
                        r_state <= S_PD_RD1;
                    end
                end
                S_PD_RD1: r_state <= S_PD_RD2;
                S_PD_RD2: begin
                    r_d  <= pend_rd0;
                    r_s0 <= sum_rd0;
                    r_s1 <= sum_rd1;
                    if (pend_rd0 == '0) begin
                        r_s     <= r_s - KW'(1);
                        r_state <= S_PD_CHK;
                    end else begin
                        r_state <= S_PD_W1;
                    end
                end
                S_PD_W1: begin
                    r_pe1   <= pend_rd1;
                    r_state <= S_PD_W2;
                end
                S_PD_W2: r_state <= S_PD_W3;
                S_PD_W3: begin
                    r_s     <= r_s - KW'(1);
                    r_state <= S_PD_CHK;
                end
                S_LP_CHK: begin
                    if (r_l >= r_r) begin
                        if (r_func == FUNC_ADD) begin
                            r_p     <= r_pl;
                            r_k     <= '0;
                            r_path  <= 1'b0;
                            r_state <= S_RF_CHK;
                        end else begin
                            r_out_sum    <= r_acc;
                            r_out_status <= 1'b0;
                            r_state      <= S_OUT;
                        end
                    end else if (r_l[0]) begin
                        r_cur   <= AW'(r_l);
                        r_l     <= r_l + NW'(1);
                        r_ret   <= 1'b0;
                        r_state <= S_AN_RD;
                    end else begin
                        r_state <= S_LP_R;
                    end
                end
                S_LP_R: begin
                    if (r_r[0]) begin
                        r_r     <= r_r - NW'(1);
                        r_cur   <= AW'(r_r - NW'(1));
                        r_ret   <= 1'b1;
                        r_state <= S_AN_RD;
                    end else begin
                        r_state <= S_LP_NEXT;
                    end
                end
                S_LP_NEXT: begin
                    r_l     <= r_l >> 1;
                    r_r     <= r_r >> 1;
                    r_k     <= r_k + KW'(1);
                    r_state <= S_LP_CHK;
                end
                S_AN_RD: r_state <= S_AN_WR;
                S_AN_WR: begin
                    r_acc   <= r_acc + SUM_W'(sum_rd0);
                    r_state <= r_ret ? S_LP_NEXT : S_LP_R;
                end
                S_RF_CHK: begin
                    if (r_p > NW'(1)) begin
                        r_p     <= r_p >> 1;
                        r_k     <= r_k + KW'(1);
                        r_state <= S_RF_RD;
                    end else if (!r_path) begin
                        r_path <= 1'b1;
                        r_p    <= r_pr;
                        r_k    <= '0;
                    end else begin
                        r_out_sum    <= '0;
                        r_out_status <= 1'b0;
                        r_state      <= S_OUT;
                    end
                end
                S_RF_RD: r_state <= S_RF_WR;
                S_RF_WR: r_state <= S_RF_CHK;
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = r_state != S_IDLE;
    assign o_valid     = r_state == S_OUT;
    assign o_sum       = r_out_sum;
    assign o_status    = r_out_status;
    assign o_cfg_ready = 1'b1;
endmodule

// ===== sv/lrast_checker.sv =====
// Port-level checker of the range add / range sum tree unit, bound to the top level.
// Depends on lazy_range_add_sum_tree_unit_assert.svh for the assertion macros.
`include "lazy_range_add_sum_tree_unit_assert.svh"

module lrast_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_sum,
    input logic        o_status
);
    // A pending result keeps the request side closed.
    `LRAST_ASSERT_NOW(a_busy_on_result, i_clk, i_rst_n, o_valid, o_stall)
    // A rejected range always reports a zero sum.
    `LRAST_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, o_valid && o_status, o_sum == 32'd0)
    // A taken request closes the request side on the next cycle.
    `LRAST_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // A held result stays put.
    `LRAST_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_sum) && $stable(o_status))
endmodule

bind lazy_range_add_sum_tree_unit lrast_checker u_lrast_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_sum(o_sum), .o_status(o_status)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the range add / range sum tree unit.
// Depends on lrast_pkg and lazy_range_add_sum_tree_unit; needs no other file.
`timescale 1ns / 1ps

module tb_top;
    import lrast_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE_CYCLES = 3500;
    localparam int NODES = 2 * LEAVES_DEF;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [POS_W-1:0]    position;
        logic [LEFT_W-1:0]   left;
        logic [RIGHT_W-1:0]  right;
        logic [AMOUNT_W-1:0] amount;
    } tree_req_t;

    typedef struct {
        logic [SUM_W-1:0] sum;
        logic             status;
    } tree_rsp_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [FUNC_W-1:0]   i_func = FUNC_WRITE;
    logic [POS_W-1:0]    i_position = '0;
    logic [LEFT_W-1:0]   i_left = '0;
    logic [RIGHT_W-1:0]  i_right = '0;
    logic signed [AMOUNT_W-1:0] i_amount = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic signed [SUM_W-1:0] o_sum;
    logic                o_status;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [SIZE_W-1:0]   i_cfg_data = SIZE_RST;

    lazy_range_add_sum_tree_unit dut (.*);

    always #10 i_clk = ~i_clk;

    // Shadow copy of the tree held by the predictor.
    logic [31:0]       shadow_sum [NODES];
    logic [31:0]       shadow_pend [NODES];
    logic [SIZE_W-1:0] shadow_size = SIZE_RST;

    tree_req_t pending_reqs[$];
    tree_rsp_t expected_rsps[$];
    int        fail_count = 0;
    int        results_seen = 0;
    int        cycle_count = 0;

    function automatic int unsigned leaves_now();
        if (shadow_size == 0) return 1;
        if (shadow_size > LEAVES_DEF) return LEAVES_DEF;
        return shadow_size;
    endfunction

    function automatic void bump_node(int unsigned n, int unsigned p, logic [31:0] v,
                                      logic [31:0] span);
        shadow_sum[p] = shadow_sum[p] + v * span;
        if (p < n) shadow_pend[p] = shadow_pend[p] + v;
    endfunction

    function automatic void refresh_path(int unsigned p);
        logic [31:0] span;
        span = 1;
        while (p > 1) begin
            p = p >> 1;
            span = span << 1;
            shadow_sum[p] = shadow_sum[2*p] + shadow_sum[2*p+1] + shadow_pend[p] * span;
        end
    endfunction

    function automatic void push_path(int unsigned n, int unsigned h, int unsigned p);
        int unsigned i;
        logic [31:0] d;
        for (int s = h; s > 0; s--) begin
            i = p >> s;
            d = shadow_pend[i];
            if (d != 0) begin
                bump_node(n, 2*i, d, 32'd1 << (s - 1));
                bump_node(n, 2*i + 1, d, 32'd1 << (s - 1));
                shadow_pend[i] = 0;
            end
        end
    endfunction

    // Applies one request to the shadow tree and queues the result it causes.
    function automatic void predict_tree(tree_req_t rq);
        int unsigned n, h, l, r, l0, r0;
        logic [31:0] span, acc;
        tree_rsp_t rsp;
        n = leaves_now();
        h = $clog2(n + 1);
        if (rq.func == FUNC_WRITE) begin
            if (rq.position < n) shadow_sum[n + rq.position] = rq.amount;
            return;
        end
        if (rq.func == FUNC_REBUILD) begin
            for (int i = n - 1; i > 0; i--) shadow_sum[i] = shadow_sum[2*i] + shadow_sum[2*i+1];
            return;
        end
        rsp.sum = '0;
        rsp.status = 1'b1;
        if (rq.left < rq.right && rq.right <= n) begin
            rsp.status = 1'b0;
            l = rq.left + n;
            r = rq.right + n;
            push_path(n, h, l);
            push_path(n, h, r - 1);
            l0 = l;
            r0 = r;
            span = 1;
            acc = 0;
            while (l < r) begin
                if (l & 1) begin
                    if (rq.func == FUNC_ADD) bump_node(n, l, rq.amount, span);
                    else acc = acc + shadow_sum[l];
                    l++;
                end
                if (r & 1) begin
                    r--;
                    if (rq.func == FUNC_ADD) bump_node(n, r, rq.amount, span);
                    else acc = acc + shadow_sum[r];
                end
                l = l >> 1;
                r = r >> 1;
                span = span << 1;
            end
            if (rq.func == FUNC_ADD) begin
                refresh_path(l0);
                refresh_path(r0 - 1);
            end else begin
                rsp.sum = acc;
            end
        end
        expected_rsps.push_back(rsp);
    endfunction

    function automatic tree_req_t make_req(logic [FUNC_W-1:0] f, int unsigned pos,
                                           int unsigned lft, int unsigned rgt,
                                           logic [31:0] amt);
        tree_req_t rq;
        rq.func = f;
        rq.position = pos;
        rq.left = lft;
        rq.right = rgt;
        rq.amount = amt;
        return rq;
    endfunction

    // Mostly valid ranges and in-range writes; the rest is raw field noise.
    function automatic tree_req_t random_req(int unsigned n);
        tree_req_t rq;
        int unsigned pick, lft;
        rq.amount = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 25) rq.func = FUNC_WRITE;
        else if (pick < ((n > 64) ? 28 : 35)) rq.func = FUNC_REBUILD;
        else rq.func = ($urandom_range(0, 1) == 1) ? FUNC_ADD : FUNC_SUM;
        if ($urandom_range(0, 99) < 80) begin
            lft = $urandom_range(0, n - 1);
            rq.left = lft;
            rq.right = $urandom_range(lft + 1, n);
            rq.position = $urandom_range(0, n - 1);
            if ($urandom_range(0, 3) == 0) rq.amount = $urandom_range(0, 15) - 8;
        end else begin
            rq.left = $urandom;
            rq.right = $urandom;
            rq.position = $urandom;
        end
        return rq;
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;
    always @(posedge i_clk) begin
        tree_req_t rq;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                rq.func = i_func;
                rq.position = i_position;
                rq.left = i_left;
                rq.right = i_right;
                rq.amount = i_amount;
                predict_tree(rq);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    rq = pending_reqs.pop_front();
                    i_func <= rq.func;
                    i_position <= rq.position;
                    i_left <= rq.left;
                    i_right <= rq.right;
                    i_amount <= rq.amount;
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own stall pattern and one long hold-off.
    int  stretch_left = 0;
    int  stall_pct = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        tree_rsp_t want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_rsps.size() == 0) begin
                    $error("unexpected result: sum %0h status %0d", o_sum, o_status);
                    fail_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_sum !== want.sum) begin
                        $error("sum: expected %0h, actual %0h", want.sum, o_sum);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        fail_count++;
                    end
                end
            end
            if (!hold_done && results_seen == 60) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(5, 60);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 40;
                    default: stall_pct = 85;
                endcase
            end
            stretch_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || expected_rsps.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        shadow_size = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [SIZE_W-1:0] sizes[8] = '{11'd1, 11'd2, 11'd7, 11'd0, 11'd64, 11'd2047,
                                        11'd33, 11'd1024};
        int unsigned n;
        for (int i = 0; i < NODES; i++) begin
            shadow_sum[i] = '0;
            shadow_pend[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_size(SIZE_RST);

        // Directed part at full size.
        pending_reqs.push_back(make_req(FUNC_WRITE, 0, 0, 0, 32'h7fff_ffff));
        pending_reqs.push_back(make_req(FUNC_WRITE, 1023, 0, 0, 32'h8000_0000));
        pending_reqs.push_back(make_req(FUNC_WRITE, 5, 0, 0, 32'hffff_ffff));
        pending_reqs.push_back(make_req(FUNC_SUM, 0, 0, 1024, 0));
        pending_reqs.push_back(make_req(FUNC_REBUILD, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_SUM, 0, 0, 1024, 0));
        pending_reqs.push_back(make_req(FUNC_ADD, 0, 0, 1024, 32'hffff_ffff));
        pending_reqs.push_back(make_req(FUNC_ADD, 0, 1023, 1024, 32'h8000_0000));
        pending_reqs.push_back(make_req(FUNC_SUM, 0, 5, 6, 0));
        pending_reqs.push_back(make_req(FUNC_SUM, 0, 1023, 1024, 0));
        pending_reqs.push_back(make_req(FUNC_ADD, 0, 3, 700, 32'd9));
        pending_reqs.push_back(make_req(FUNC_SUM, 0, 1, 699, 0));
        // A rebuild keeps pending increments, so sums go stale on purpose.
        pending_reqs.push_back(make_req(FUNC_REBUILD, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_SUM, 0, 0, 1024, 0));
        pending_reqs.push_back(make_req(FUNC_SUM, 0, 7, 7, 0));
        pending_reqs.push_back(make_req(FUNC_ADD, 0, 9, 4, 32'd1));
        pending_reqs.push_back(make_req(FUNC_SUM, 0, 0, 1025, 0));
        pending_reqs.push_back(make_req(FUNC_ADD, 0, 1023, 2047, 32'd1));
        pending_reqs.push_back(make_req(FUNC_SUM, 0, 1023, 1024, 0));
        wait_idle();

        foreach (sizes[k]) begin
            write_size(sizes[k]);
            n = leaves_now();
            // Out-of-range leaf write when the tree is smaller than the store.
            pending_reqs.push_back(make_req(FUNC_WRITE, 1023, 0, 0, 32'h1234_5678));
            for (int j = 0; j < 55; j++) pending_reqs.push_back(random_req(n));
            wait_idle();
        end

        if (fail_count == 0 && expected_rsps.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/lrast_pkg.sv
sv/lrast_ram.sv
sv/lrast_alu.sv
sv/lazy_range_add_sum_tree_unit.sv
sv/lrast_checker.sv
tb/tb_top.sv
